// ----- rtl/core/sadf_pkg.sv -----
// Shared types and constants of the set-associative duplicate filter.
package sadf_pkg;

  localparam int unsigned VertexW  = 32;
  localparam int unsigned CompactW = 31;
  localparam int unsigned KindW    = 2;
  localparam int unsigned BankBit  = 6;

  typedef enum logic [KindW-1:0] {
    KIND_VERTEX     = 2'd0,
    KIND_NEW_LEVEL  = 2'd1,
    KIND_NEW_SEARCH = 2'd2,
    KIND_UNUSED     = 2'd3
  } kind_e;

  // Drops the bank select bit from a vertex index.
  function automatic logic [CompactW-1:0] compact_index(input logic [VertexW-1:0] v);
    compact_index = {v[VertexW-1:BankBit+1], v[BankBit-1:0]};
  endfunction

endpackage

// ----- rtl/core/sadf_tag_ram.sv -----
// Simple dual-port tag memory with one registered read port and one write port.
module sadf_tag_ram #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned Width = 72
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/set_assoc_duplicate_filter_top.sv -----
// Top level of the set-associative duplicate filter for vertex index streams.
// A vertex beat that misses passes from the stage-one registers to the output register.
// Throughput: one beat per cycle while the output is not stalled and no sweep runs.
// A new-search beat empties every set with a sweep, one set per cycle.
// Reset runs the same sweep; no beat is accepted until it ends.
// Reset is asynchronous and active low; it clears the control state and the victim pointer.
module set_assoc_duplicate_filter_top #(
  parameter int unsigned SETS = 16384,
  parameter int unsigned WAYS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] vertex
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [30:0] compact_vertex, [31] zero
);

  // SETS is taken as a power of two: the low bits of the compacted index pick
  // the set and the rest, widened by one bit, form the tag. The extra top bit is
  // always clear on a real tag, so an all-ones tag marks an empty way.
  localparam int unsigned SetW  = $clog2(SETS);
  localparam int unsigned TagW  = sadf_pkg::VertexW - SetW;
  localparam int unsigned VicW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned LineW = WAYS * TagW;
  localparam logic [VicW-1:0] VicLast = VicW'(WAYS - 1);
  localparam logic [SetW-1:0] SetLast = SetW'(SETS - 1);

  typedef logic [WAYS-1:0][TagW-1:0] line_t;

  // ---------------------------------------------------------------------------
  // Input side. The tag line of the incoming vertex is read as the beat is
  // accepted, so the data arrives together with the beat in stage one.
  // ---------------------------------------------------------------------------
  sadf_pkg::kind_e              in_kind;
  logic [sadf_pkg::CompactW-1:0] in_compact;
  logic                          in_accept;

  assign in_kind    = sadf_pkg::kind_e'(s_axis_tuser_i);
  assign in_compact = sadf_pkg::compact_index(s_axis_tdata_i);
  assign in_accept  = s_axis_tvalid_i & s_axis_tready_o;

  // Stage one registers.
  logic                          s1_valid_q;
  sadf_pkg::kind_e               s1_kind_q;
  logic [sadf_pkg::CompactW-1:0] s1_compact_q;

  // Forwarding register: the write that took place in the cycle in which the
  // stage-one beat read its line. The memory returns old data in that case.
  logic            fwd_valid_q;
  logic [SetW-1:0] fwd_set_q;
  line_t           fwd_line_q;

  // Clearing sweep and round-robin victim pointer.
  logic            clr_active_q, clr_active_d;
  logic [SetW-1:0] clr_cnt_q, clr_cnt_d;
  logic [VicW-1:0] vic_q, vic_d;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic [sadf_pkg::CompactW-1:0] out_data_q;

  // ---------------------------------------------------------------------------
  // Stage one: tag compare, victim selection and write-back.
  // ---------------------------------------------------------------------------
  logic [SetW-1:0] s1_set;
  logic [TagW-1:0] s1_tag;
  logic [LineW-1:0] ram_rdata;
  line_t           s1_line;
  line_t           s1_new_line;
  logic            s1_hit;
  logic            s1_is_vertex;
  logic            s1_stall;
  logic            s1_fire;
  logic            s1_wr_en;
  logic            s1_miss;

  assign s1_set       = s1_compact_q[SetW-1:0];
  assign s1_tag       = TagW'(s1_compact_q[sadf_pkg::CompactW-1:SetW]);
  assign s1_is_vertex = s1_valid_q & (s1_kind_q == sadf_pkg::KIND_VERTEX);
  assign s1_line      = (fwd_valid_q && (fwd_set_q == s1_set)) ? fwd_line_q
                                                              : line_t'(ram_rdata);

  always_comb begin
    s1_hit = 1'b0;
    for (int unsigned w = 0; w < WAYS; w++) begin
      if (s1_line[w] == s1_tag) begin
        s1_hit = 1'b1;
      end
    end
  end

  always_comb begin
    s1_new_line        = s1_line;
    s1_new_line[vic_q] = s1_tag;
  end

  // A vertex waits only while the output register still holds an untaken beat.
  assign s1_stall = s1_is_vertex & out_valid_q & ~m_axis_tready_i;
  assign s1_fire  = s1_valid_q & ~s1_stall;
  assign s1_miss  = s1_fire & s1_is_vertex & ~s1_hit;
  assign s1_wr_en = s1_miss;

  // No beat enters while a new-search beat waits in stage one or the sweep runs,
  // so every read after a new search sees the emptied memory.
  assign s_axis_tready_o = ~clr_active_q
                         & ~(s1_valid_q && (s1_kind_q == sadf_pkg::KIND_NEW_SEARCH))
                         & (~s1_valid_q | s1_fire);

  // ---------------------------------------------------------------------------
  // Next-state logic for the victim pointer, the sweep and the output.
  // ---------------------------------------------------------------------------
  always_comb begin
    vic_d        = vic_q;
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      clr_cnt_d = clr_cnt_q + SetW'(1);
      if (clr_cnt_q == SetLast) begin
        clr_active_d = 1'b0;
      end
    end
    if (s1_fire) begin
      unique case (s1_kind_q)
        sadf_pkg::KIND_VERTEX: begin
          if (s1_miss) begin
            vic_d = (vic_q == VicLast) ? '0 : vic_q + VicW'(1);
          end
        end
        sadf_pkg::KIND_NEW_LEVEL: begin
          vic_d = '0;
        end
        sadf_pkg::KIND_NEW_SEARCH: begin
          vic_d        = '0;
          clr_active_d = 1'b1;
          clr_cnt_d    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_miss) begin
      out_valid_d = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      vic_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      vic_q        <= vic_d;
      out_valid_q  <= out_valid_d;
      if (in_accept) begin
        s1_valid_q  <= 1'b1;
        fwd_valid_q <= s1_wr_en;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q    <= in_kind;
      s1_compact_q <= in_compact;
      fwd_set_q    <= s1_set;
      fwd_line_q   <= s1_new_line;
    end
    if (s1_miss) begin
      out_data_q <= s1_compact_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Tag memory: the sweep owns the write port while it runs.
  // ---------------------------------------------------------------------------
  logic             ram_we;
  logic [SetW-1:0]  ram_waddr;
  logic [LineW-1:0] ram_wdata;

  assign ram_we    = clr_active_q | s1_wr_en;
  assign ram_waddr = clr_active_q ? clr_cnt_q : s1_set;
  assign ram_wdata = clr_active_q ? '1 : LineW'(s1_new_line);

  sadf_tag_ram #(
    .Depth (SETS),
    .Width (LineW)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (in_compact[SetW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_data_q};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !s_axis_tready_o)
    else $error("beat accepted during the clearing sweep");

  a_miss_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_miss |=> m_axis_tvalid_o)
    else $error("a miss did not produce an output beat");

  a_search_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_kind_q == sadf_pkg::KIND_NEW_SEARCH) |=> clr_active_q && clr_cnt_q == '0)
    else $error("a new search did not start the clearing sweep");

  a_vic_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vic_q <= VicLast)
    else $error("victim pointer beyond the last way");

  a_hit_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_is_vertex && s1_hit && !m_axis_tready_i && !out_valid_q)
      |=> !m_axis_tvalid_o)
    else $error("a hit produced an output beat");

endmodule
